### design/mlsd_pkg.sv
package mlsd_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned AddrWidth  = 64;
  localparam int unsigned CountWidth = 6;
  localparam int unsigned RegWidth   = 5;

  localparam int unsigned SDataWidth = 224;
  localparam int unsigned SUserWidth = 2;
  localparam int unsigned MDataWidth = 152;
  localparam int unsigned MUserWidth = 4;

  localparam logic [AddrWidth-1:0] LowPcLimit = 64'h0000_0000_0001_0000;
  localparam logic [2:0] StrhLslOption = 3'b011;

  localparam logic [InstrWidth-1:0] MaskImm12    = 32'hBFC0_0000;
  localparam logic [InstrWidth-1:0] MaskImm9     = 32'hBFE0_0C00;
  localparam logic [InstrWidth-1:0] MaskVecSc    = 32'h3F40_0000;
  localparam logic [InstrWidth-1:0] MaskVecUs    = 32'h3F60_0C00;
  localparam logic [InstrWidth-1:0] MaskHalfImm  = 32'hFFC0_0000;
  localparam logic [InstrWidth-1:0] MaskHalfImm9 = 32'hFFE0_0C00;
  localparam logic [InstrWidth-1:0] MaskLane     = 32'hBFFF_FC00;

  localparam logic [InstrWidth-1:0] EncStrImm   = 32'hB900_0000;
  localparam logic [InstrWidth-1:0] EncStur     = 32'hB800_0000;
  localparam logic [InstrWidth-1:0] EncVStrSc   = 32'h3D00_0000;
  localparam logic [InstrWidth-1:0] EncVStrUs   = 32'h3C00_0000;
  localparam logic [InstrWidth-1:0] EncVLdrSc   = 32'h3D40_0000;
  localparam logic [InstrWidth-1:0] EncVLdrUs   = 32'h3C40_0000;
  localparam logic [InstrWidth-1:0] EncLdrImm   = 32'hB940_0000;
  localparam logic [InstrWidth-1:0] EncLdur     = 32'hB840_0000;
  localparam logic [InstrWidth-1:0] EncStrhImm  = 32'h7900_0000;
  localparam logic [InstrWidth-1:0] EncSturh    = 32'h7800_0000;
  localparam logic [InstrWidth-1:0] EncStrhReg  = 32'h7820_0800;
  localparam logic [InstrWidth-1:0] EncStpX     = 32'hA900_0000;
  localparam logic [InstrWidth-1:0] EncStpQ     = 32'hAD00_0000;
  localparam logic [InstrWidth-1:0] EncSt1Lane  = 32'h0D00_8400;
  localparam logic [InstrWidth-1:0] EncLdrPost  = 32'hB840_0400;
  localparam logic [InstrWidth-1:0] EncStrPost  = 32'hB800_0400;

  typedef enum logic [2:0] {
    KIND_LD     = 3'd0,
    KIND_ST     = 3'd1,
    KIND_VLD    = 3'd2,
    KIND_VST    = 3'd3,
    KIND_PAIR   = 3'd4,
    KIND_VPAIR  = 3'd5,
    KIND_LANE   = 3'd6
  } kind_t;

  typedef struct packed {
    logic                  supported;
    kind_t                 kind;
    logic [RegWidth-1:0]   data_reg;
    logic [RegWidth-1:0]   second_reg;
    logic                  lane_select;
    logic [AddrWidth-1:0]  offset;
    logic [AddrWidth-1:0]  post_offset;
    logic [CountWidth-1:0] byte_count;
    logic                  word_path;
    logic                  base_update;
    logic [RegWidth-1:0]   base_reg;
  } dec_t;

endpackage

### design/mlsd_decode.sv
module mlsd_decode (
  input  logic [mlsd_pkg::InstrWidth-1:0] instruction,
  input  logic [mlsd_pkg::AddrWidth-1:0]  fault_pc,
  input  logic [mlsd_pkg::AddrWidth-1:0]  index_value,
  input  logic                            vector_context_present,
  output mlsd_pkg::dec_t                  dec
);
  import mlsd_pkg::*;

  logic [InstrWidth-1:0] w;
  logic [1:0]            sz;
  logic [11:0]           imm12;
  logic [2:0]            vscale;
  logic [AddrWidth-1:0]  simm9;
  logic [AddrWidth-1:0]  simm7;
  logic [AddrWidth-1:0]  imm12_sz;
  logic [AddrWidth-1:0]  imm12_vs;
  logic [CountWidth-1:0] count_sz;
  logic                  ok;
  logic                  is_vec;

  assign w        = instruction;
  assign sz       = w[31:30];
  assign imm12    = w[21:10];
  assign vscale   = {1'b0, sz} + (w[23] ? 3'd4 : 3'd0);
  assign simm9    = {{(AddrWidth-9){w[20]}}, w[20:12]};
  assign simm7    = {{(AddrWidth-7){w[21]}}, w[21:15]};
  assign imm12_sz = {52'b0, imm12} << sz;
  assign imm12_vs = {52'b0, imm12} << vscale;
  assign count_sz = CountWidth'(1) << sz;
  assign is_vec   = ((w & MaskVecSc) == EncVStrSc) || ((w & MaskVecUs) == EncVStrUs) ||
                    ((w & MaskVecSc) == EncVLdrSc) || ((w & MaskVecUs) == EncVLdrUs);

  always_comb begin
    dec             = '0;
    ok              = 1'b0;
    dec.data_reg    = w[4:0];
    dec.base_reg    = w[9:5];
    dec.post_offset = simm9;
    if ((w & MaskImm12) == EncStrImm) begin
      ok = 1'b1; dec.kind = KIND_ST; dec.offset = imm12_sz;
      dec.byte_count = count_sz; dec.word_path = (sz == 2'd3);
    end else if ((w & MaskImm9) == EncStur) begin
      ok = 1'b1; dec.kind = KIND_ST; dec.offset = simm9;
      dec.byte_count = count_sz; dec.word_path = (sz == 2'd3);
    end else if (is_vec) begin
      ok = (vscale <= 3'd4) && vector_context_present;
      dec.kind = w[22] ? KIND_VLD : KIND_VST;
      dec.offset = w[24] ? imm12_vs : simm9;
      dec.byte_count = CountWidth'(1) << vscale;
      dec.word_path = (vscale > 3'd2);
    end else if ((w & MaskImm12) == EncLdrImm) begin
      ok = 1'b1; dec.kind = KIND_LD; dec.offset = imm12_sz;
      dec.byte_count = count_sz; dec.word_path = (sz == 2'd3);
    end else if ((w & MaskImm9) == EncLdur) begin
      ok = 1'b1; dec.kind = KIND_LD; dec.offset = simm9;
      dec.byte_count = count_sz; dec.word_path = (sz == 2'd3);
    end else if ((w & MaskHalfImm) == EncStrhImm) begin
      ok = 1'b1; dec.kind = KIND_ST; dec.offset = {51'b0, imm12, 1'b0};
      dec.byte_count = CountWidth'(2);
    end else if ((w & MaskHalfImm9) == EncSturh) begin
      ok = 1'b1; dec.kind = KIND_ST; dec.offset = simm9;
      dec.byte_count = CountWidth'(2);
    end else if ((w & MaskHalfImm9) == EncStrhReg) begin
      ok = (w[15:13] == StrhLslOption);
      dec.kind = KIND_ST;
      dec.offset = w[12] ? {index_value[AddrWidth-2:0], 1'b0} : index_value;
      dec.byte_count = CountWidth'(2);
    end else if ((w & MaskHalfImm) == EncStpX) begin
      ok = 1'b1; dec.kind = KIND_PAIR; dec.second_reg = w[14:10];
      dec.offset = {simm7[AddrWidth-4:0], 3'b0};
      dec.byte_count = CountWidth'(16); dec.word_path = 1'b1;
    end else if ((w & MaskHalfImm) == EncStpQ) begin
      ok = vector_context_present; dec.kind = KIND_VPAIR; dec.second_reg = w[14:10];
      dec.offset = {simm7[AddrWidth-5:0], 4'b0};
      dec.byte_count = CountWidth'(32); dec.word_path = 1'b1;
    end else if ((w & MaskLane) == EncSt1Lane) begin
      ok = vector_context_present; dec.kind = KIND_LANE; dec.lane_select = w[30];
      dec.byte_count = CountWidth'(8); dec.word_path = 1'b1;
    end else if (((w & MaskImm9) == EncLdrPost) || ((w & MaskImm9) == EncStrPost)) begin
      ok = 1'b1; dec.kind = w[22] ? KIND_LD : KIND_ST;
      dec.byte_count = count_sz; dec.word_path = (sz == 2'd3);
      dec.base_update = 1'b1;
    end
    dec.supported = ok && (fault_pc >= LowPcLimit);
  end

endmodule

### design/misaligned_load_store_decode.sv
// Throughput: one instruction per cycle while m_tready holds; stages: decode, address add, mask/align.
// Each stage holds while the one after it is full and stalled.
// Reset: synchronous, active high; clears the stage valid bits only.
module misaligned_load_store_decode (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // instruction[31:0], fault_pc[95:32], base_value[159:96], index_value[223:160]
  input  logic [mlsd_pkg::SDataWidth-1:0] s_tdata,
  // address_32bit[0], vector_context_present[1]
  input  logic [mlsd_pkg::SUserWidth-1:0] s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // data_reg[4:0], second_reg[9:5], lane_select[10], access_address[74:11],
  // byte_count[80:75], word_path[81], base_update[82], base_reg[87:83],
  // base_new_value[151:88]
  output logic [mlsd_pkg::MDataWidth-1:0] m_tdata,
  // supported[0], access_kind[3:1]
  output logic [mlsd_pkg::MUserWidth-1:0] m_tuser
);
  import mlsd_pkg::*;

  dec_t                 dec;
  logic                 adv1, adv2, adv3;

  logic                 v1;
  dec_t                 d1;
  logic [AddrWidth-1:0] base1;
  logic                 a32_1;

  logic                 v2;
  dec_t                 d2;
  logic [AddrWidth-1:0] addr2;
  logic [AddrWidth-1:0] newbase2;
  logic                 a32_2;

  logic                 v3;
  logic [MDataWidth-1:0] data3;
  logic [MUserWidth-1:0] user3;

  logic [AddrWidth-1:0]  addr_m;
  logic                  word_m;

  mlsd_decode u_decode (
    .instruction            (s_tdata[31:0]),
    .fault_pc               (s_tdata[95:32]),
    .index_value            (s_tdata[223:160]),
    .vector_context_present (s_tuser[1]),
    .dec                    (dec)
  );

  assign adv3     = !v3 || m_tready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && s_tvalid) begin
      d1    <= dec;
      base1 <= s_tdata[159:96];
      a32_1 <= s_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      d2       <= d1;
      addr2    <= base1 + d1.offset;
      newbase2 <= d1.base_update ? base1 + d1.post_offset : '0;
      a32_2    <= a32_1;
    end
  end

  assign addr_m = a32_2 ? {32'b0, addr2[31:0]} : addr2;
  assign word_m = d2.word_path && (addr_m[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      if (d2.supported) begin
        data3 <= {newbase2, d2.base_reg, d2.base_update, word_m, d2.byte_count,
                  addr_m, d2.lane_select, d2.second_reg, d2.data_reg};
        user3 <= {d2.kind, 1'b1};
      end else begin
        data3 <= '0;
        user3 <= '0;
      end
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = data3;
  assign m_tuser  = user3;

  a_unsupported_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0 && m_tuser == '0))
    else $error("unsupported result carries nonzero fields");

  a_word_aligned: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[81]) |-> (m_tdata[12:11] == 2'b00))
    else $error("word path on unaligned address");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[80:75] != '0))
    else $error("supported result with zero byte count");

  a_stage2_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !adv2) |=> (v2 && $stable(addr2) && $stable(newbase2)))
    else $error("stage two lost data while stalled");

  a_update_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[82]) |-> (m_tuser[3:1] == KIND_LD || m_tuser[3:1] == KIND_ST))
    else $error("base writeback on a non-scalar access");

endmodule
